### hdl/assert_macros.svh
// assertion macros shared by the checker files
// expects signals named clock and reset in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define WIP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication failed");
// next-cycle implication
`define WIP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`endif

### hdl/wip_pkg.sv
// shared types, codes and helpers of the interval overlap resolver
// no dependencies
`default_nettype none
package wip_pkg;
   localparam int KEPT_DEPTH_DEF = 32;
   localparam int COORD_W = 31;
   localparam int WEIGHT_W = 40;
   localparam int ID_W = 16;

   localparam logic [1:0] OP_FEATURE = 2'd0;
   localparam logic [1:0] OP_CLOSE   = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   localparam logic [1:0] KIND_DECISION = 2'd0;
   localparam logic [1:0] KIND_DISCARD  = 2'd1;
   localparam logic [1:0] KIND_ENTRY    = 2'd2;

   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_LOAD  = 2'd1;
   localparam logic [1:0] CELL_LEFT  = 2'd2;
   localparam logic [1:0] CELL_RIGHT = 2'd3;

   typedef struct packed {
      logic [COORD_W-1:0]  start_pos;
      logic [COORD_W-1:0]  end_pos;
      logic [WEIGHT_W-1:0] weight;
      logic [ID_W-1:0]     id;
   } entry_type;

   // clamp a 41-bit signed value to the 40-bit signed range
   function automatic logic [WEIGHT_W-1:0] sat40(input logic [WEIGHT_W:0] v);
      logic [WEIGHT_W-1:0] r;
      if (v[WEIGHT_W] == v[WEIGHT_W-1]) r = v[WEIGHT_W-1:0];
      else if (v[WEIGHT_W]) r = {1'b1, {(WEIGHT_W-1){1'b0}}};
      else r = {1'b0, {(WEIGHT_W-1){1'b1}}};
      return r;
   endfunction
endpackage
`default_nettype wire

### hdl/wip_cell.sv
// one table slot of the kept-interval chain
// depends on wip_pkg
`default_nettype none
module wip_cell (
   input  wire logic              clock,
   input  wire logic [1:0]        mode,
   input  wire wip_pkg::entry_type new_entry,
   input  wire wip_pkg::entry_type left_entry,
   input  wire wip_pkg::entry_type right_entry,
   output wip_pkg::entry_type     entry
);
   import wip_pkg::*;
   entry_type entry_ff, entry_in;

   // take new data, a neighbour's, or hold
   always_comb begin
      unique case (mode)
         CELL_LOAD:  entry_in = new_entry;
         CELL_LEFT:  entry_in = left_entry;
         CELL_RIGHT: entry_in = right_entry;
         default:    entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire

### hdl/weighted_interval_overlap_resolver.sv
// top level: control sequencer and the chain of table cells
// depends on wip_pkg and wip_cell
//
// channel   ports            handshake
// req       start/busy       beat taken when start high and busy low
// rsp       rsp_valid        one-cycle strobe, always taken
//
// feature items leave the block idle and give no result; a read gives one
// result via the read state and the result register. A close that starts
// past every kept entry skips the scan; else it scans the kept count once
// and walks the overlap run down and up, one cell per cycle through the
// single read mux, then shifts the chain one slot per displaced entry.
// Synchronous reset empties the table at once; no clearing pass.
`default_nettype none
module weighted_interval_overlap_resolver #(
   parameter int KEPT_DEPTH = wip_pkg::KEPT_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_group_id,
   input  wire logic [31:0] req_feature_score,
   input  wire logic        req_score_null,
   input  wire logic [30:0] req_group_start,
   input  wire logic [30:0] req_group_end,
   input  wire logic [4:0]  req_read_index,
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic [15:0]      rsp_out_group_id,
   output logic             rsp_accepted,
   output logic             rsp_table_full,
   output logic [30:0]      rsp_entry_start,
   output logic [30:0]      rsp_entry_end,
   output logic             rsp_entry_valid,
   output logic [5:0]       rsp_kept_total,
   output logic             rsp_last
);
   import wip_pkg::*;

   localparam int IW = (KEPT_DEPTH > 1) ? $clog2(KEPT_DEPTH) : 1;
   localparam int CW = $clog2(KEPT_DEPTH + 1);
   localparam int PW = CW + 1;
   localparam int AW = WEIGHT_W + IW + 1;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_READ   = 4'd1;
   localparam logic [3:0] ST_SCAN   = 4'd2;
   localparam logic [3:0] ST_DOWN   = 4'd3;
   localparam logic [3:0] ST_UP     = 4'd4;
   localparam logic [3:0] ST_JUDGE  = 4'd5;
   localparam logic [3:0] ST_REMOVE = 4'd6;
   localparam logic [3:0] ST_INSERT = 4'd7;
   localparam logic [3:0] ST_DROP   = 4'd8;
   localparam logic [3:0] ST_DECIDE = 4'd9;

   logic [3:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic signed [31:0]   high_ff, high_in;
   logic [WEIGHT_W-1:0]  sum_ff, sum_in;
   logic                 any_ff, any_in;
   logic signed [PW-1:0] ptr_ff, ptr_in, li_ff, li_in, lo_ff, lo_in;
   logic [CW-1:0]        nr_ff, nr_in, pos_ff, pos_in, total_ff, total_in;
   logic signed [AW-1:0] alt_ff, alt_in;
   logic                 acc_ff, acc_in, full_ff, full_in, rvalid_ff, rvalid_in;
   entry_type            cand_ff, cand_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           kind_ff, kind_in;
   logic [ID_W-1:0]      oid_ff, oid_in;
   logic                 oacc_ff, oacc_in, ofull_ff, ofull_in, oval_ff, oval_in;
   logic                 last_ff, last_in;
   logic [COORD_W-1:0]   ost_ff, ost_in, oen_ff, oen_in;
   logic [5:0]           otot_ff, otot_in;

   entry_type            cells [KEPT_DEPTH];
   logic [1:0]           modes [KEPT_DEPTH];
   entry_type            rd;
   logic                 ptr_in_table;
   logic [WEIGHT_W:0]    feat_sum, span_w;
   logic signed [32:0]   span;
   logic signed [AW-1:0] cand_wide, rd_wide;

   // the chain itself
   for (genvar i = 0; i < KEPT_DEPTH; i++) begin : g_cell
      always_comb begin
         modes[i] = CELL_HOLD;
         if (state_ff == ST_REMOVE && CW'(i) >= pos_ff) modes[i] = CELL_RIGHT;
         if (state_ff == ST_INSERT && CW'(i) > pos_ff) modes[i] = CELL_LEFT;
         if (state_ff == ST_INSERT && CW'(i) == pos_ff) modes[i] = CELL_LOAD;
      end
      wip_cell u_cell (
         .clock       (clock),
         .mode        (modes[i]),
         .new_entry   (cand_ff),
         .left_entry  (cells[(i > 0) ? i - 1 : i]),
         .right_entry (cells[(i < KEPT_DEPTH - 1) ? i + 1 : i]),
         .entry       (cells[i])
      );
   end

   // single read port at the walking pointer
   assign rd = cells[ptr_ff[IW-1:0]];
   assign ptr_in_table = !ptr_ff[PW-1] && (ptr_ff < $signed({1'b0, count_ff}));
   assign cand_wide = $signed({{(AW-WEIGHT_W){cand_ff.weight[WEIGHT_W-1]}}, cand_ff.weight});
   assign rd_wide = $signed({{(AW-WEIGHT_W){rd.weight[WEIGHT_W-1]}}, rd.weight});

   // weight arithmetic for feature and close beats
   assign feat_sum = {sum_ff[WEIGHT_W-1], sum_ff}
                   + {{(WEIGHT_W-31){req_feature_score[31]}}, req_feature_score};
   assign span = $signed({2'b00, req_group_end}) - $signed({2'b00, req_group_start})
               + 33'sd1;
   assign span_w = {span, 8'b0};

   // sequencer
   always_comb begin
      state_in = state_ff; count_in = count_ff; high_in = high_ff;
      sum_in = sum_ff; any_in = any_ff; ptr_in = ptr_ff; li_in = li_ff;
      lo_in = lo_ff; nr_in = nr_ff; pos_in = pos_ff; total_in = total_ff;
      alt_in = alt_ff; acc_in = acc_ff; full_in = full_ff; rvalid_in = rvalid_ff;
      cand_in = cand_ff;
      rsp_valid_in = 1'b0; kind_in = KIND_DECISION; oid_in = '0; oacc_in = 1'b0;
      ofull_in = 1'b0; oval_in = 1'b0; last_in = 1'b0; ost_in = '0; oen_in = '0;
      otot_in = 6'(count_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_operation)
                  OP_FEATURE: begin
                     if (!req_score_null) begin
                        sum_in = sat40(feat_sum);
                        any_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     ptr_in = PW'(req_read_index);
                     rvalid_in = 6'(req_read_index) < 6'(count_ff);
                     state_in = ST_READ;
                  end
                  OP_CLOSE: begin
                     cand_in.start_pos = req_group_start;
                     cand_in.end_pos = req_group_end;
                     cand_in.id = req_group_id;
                     cand_in.weight = any_ff ? sum_ff : sat40(span_w);
                     sum_in = '0;
                     any_in = 1'b0;
                     acc_in = 1'b0;
                     full_in = 1'b0;
                     if ($signed({1'b0, req_group_start}) > high_ff) begin
                        if (32'(count_ff) >= 32'(KEPT_DEPTH)) begin
                           full_in = 1'b1;
                           total_in = count_ff;
                           state_in = ST_DROP;
                        end else begin
                           pos_in = count_ff;
                           state_in = ST_INSERT;
                        end
                     end else begin
                        ptr_in = '0;
                        li_in = -PW'(1);
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1; kind_in = KIND_ENTRY; last_in = 1'b1;
            oval_in = rvalid_ff;
            if (rvalid_ff) begin
               oid_in = rd.id; ost_in = rd.start_pos; oen_in = rd.end_pos;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (ptr_in_table) begin
               if (rd.start_pos <= cand_ff.start_pos) li_in = ptr_ff;
               ptr_in = ptr_ff + PW'(1);
            end else begin
               ptr_in = li_ff;
               alt_in = '0;
               state_in = ST_DOWN;
            end
         end
         ST_DOWN: begin
            if (!ptr_ff[PW-1] && rd.end_pos >= cand_ff.start_pos) begin
               alt_in = alt_ff + rd_wide;
               ptr_in = ptr_ff - PW'(1);
            end else begin
               lo_in = ptr_ff + PW'(1);
               ptr_in = li_ff + PW'(1);
               state_in = ST_UP;
            end
         end
         ST_UP: begin
            if (ptr_in_table && rd.start_pos <= cand_ff.end_pos) begin
               alt_in = alt_ff + rd_wide;
               ptr_in = ptr_ff + PW'(1);
            end else begin
               nr_in = CW'(ptr_ff - lo_ff);
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            if (nr_ff != '0) begin
               if (cand_wide > alt_ff) begin
                  pos_in = CW'(lo_ff);
                  ptr_in = lo_ff;
                  total_in = count_ff - nr_ff + CW'(1);
                  state_in = ST_REMOVE;
               end else begin
                  total_in = count_ff;
                  state_in = ST_DROP;
               end
            end else if (32'(count_ff) >= 32'(KEPT_DEPTH)) begin
               full_in = 1'b1;
               total_in = count_ff;
               state_in = ST_DROP;
            end else begin
               pos_in = CW'(li_ff + PW'(1));
               state_in = ST_INSERT;
            end
         end
         ST_REMOVE: begin
            rsp_valid_in = 1'b1; kind_in = KIND_DISCARD; oid_in = rd.id;
            otot_in = 6'(total_ff);
            count_in = count_ff - CW'(1);
            nr_in = nr_ff - CW'(1);
            if (nr_ff == CW'(1)) state_in = ST_INSERT;
         end
         ST_INSERT: begin
            count_in = count_ff + CW'(1);
            acc_in = 1'b1;
            if ($signed({1'b0, cand_ff.end_pos}) > high_ff)
               high_in = $signed({1'b0, cand_ff.end_pos});
            state_in = ST_DECIDE;
         end
         ST_DROP: begin
            rsp_valid_in = 1'b1; kind_in = KIND_DISCARD; oid_in = cand_ff.id;
            otot_in = 6'(total_ff);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            rsp_valid_in = 1'b1; kind_in = KIND_DECISION; oid_in = cand_ff.id;
            oacc_in = acc_ff; ofull_in = full_ff; last_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         high_ff <= -32'sd1;
         sum_ff <= '0;
         any_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         high_ff <= high_in;
         sum_ff <= sum_in;
         any_ff <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in; li_ff <= li_in; lo_ff <= lo_in; nr_ff <= nr_in;
      pos_ff <= pos_in; total_ff <= total_in; alt_ff <= alt_in;
      acc_ff <= acc_in; full_ff <= full_in; rvalid_ff <= rvalid_in;
      cand_ff <= cand_in;
      kind_ff <= kind_in; oid_ff <= oid_in; oacc_ff <= oacc_in; ofull_ff <= ofull_in;
      oval_ff <= oval_in; last_ff <= last_in; ost_ff <= ost_in; oen_ff <= oen_in;
      otot_ff <= otot_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_out_group_id = oid_ff;
   assign rsp_accepted = oacc_ff;
   assign rsp_table_full = ofull_ff;
   assign rsp_entry_start = ost_ff;
   assign rsp_entry_end = oen_ff;
   assign rsp_entry_valid = oval_ff;
   assign rsp_kept_total = otot_ff;
   assign rsp_last = last_ff;
endmodule
`default_nettype wire

### hdl/wip_checker.sv
// port-level checks on the resolver, bound to the top level
// depends on wip_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module wip_checker #(
   parameter int KEPT_DEPTH = wip_pkg::KEPT_DEPTH_DEF
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_operation,
   input wire logic       rsp_valid,
   input wire logic [1:0] rsp_kind,
   input wire logic [5:0] rsp_kept_total,
   input wire logic       rsp_last
);
   import wip_pkg::*;

   // an accepted close beat leaves the block busy in the cycle after
   `WIP_ASSERT_NXT(a_close_busy, start && !busy && req_operation == OP_CLOSE, busy)
   // read beats end their input; discard beats never do
   `WIP_ASSERT_IMP(a_read_last, rsp_valid && rsp_kind == KIND_ENTRY, rsp_last)
   `WIP_ASSERT_IMP(a_discard_not_last, rsp_valid && rsp_kind == KIND_DISCARD, !rsp_last)
   // kept count never exceeds the table
   `WIP_ASSERT_IMP(a_total_bound, rsp_valid, 32'(rsp_kept_total) <= 32'(KEPT_DEPTH))
endmodule

bind weighted_interval_overlap_resolver wip_checker #(.KEPT_DEPTH(KEPT_DEPTH)) u_wip_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_operation  (req_operation),
   .rsp_valid      (rsp_valid),
   .rsp_kind       (rsp_kind),
   .rsp_kept_total (rsp_kept_total),
   .rsp_last       (rsp_last)
);
`default_nettype wire

### verif/tb.sv
// self-checking testbench of the weighted interval overlap resolver
// depends on wip_pkg and the resolver rtl; holds its own table predictor
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wip_pkg::*;

   localparam int         DEPTH     = 32;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam longint     WMAX      = 64'sd549755813887;
   localparam longint     WMIN      = -64'sd549755813888;
   localparam logic [30:0] CMAX     = 31'h7fffffff;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] id;
      logic        acc;
      logic        full;
      logic [30:0] s;
      logic [30:0] e;
      logic        valid;
      logic [5:0]  total;
      logic        last;
   } rsp_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = OP_FEATURE;
   logic [15:0] req_group_id = '0;
   logic [31:0] req_feature_score = '0;
   logic        req_score_null = 1'b0;
   logic [30:0] req_group_start = '0;
   logic [30:0] req_group_end = '0;
   logic [4:0]  req_read_index = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_out_group_id;
   logic        rsp_accepted;
   logic        rsp_table_full;
   logic [30:0] rsp_entry_start;
   logic [30:0] rsp_entry_end;
   logic        rsp_entry_valid;
   logic [5:0]  rsp_kept_total;
   logic        rsp_last;

   weighted_interval_overlap_resolver DUT (.*);

   always #2 clock = ~clock;

   // predictor state: the kept table and the open group
   longint      kept_lo[DEPTH];
   longint      kept_hi[DEPTH];
   longint      kept_w[DEPTH];
   logic [15:0] kept_id[DEPTH];
   int          kept_n = 0;
   longint      reach = -1;
   longint      group_sum = 0;
   bit          group_scored = 0;

   rsp_beat_type pending_beats[$];
   int          error_count = 0;
   bit          no_gaps = 0;

   function automatic longint clamp_weight(longint v);
      if (v > WMAX) return WMAX;
      if (v < WMIN) return WMIN;
      return v;
   endfunction

   function automatic void push_beat(logic [1:0] kind, logic [15:0] id, logic acc,
                                     logic full, logic [30:0] s, logic [30:0] e,
                                     logic valid, logic last);
      rsp_beat_type b;
      b.kind = kind; b.id = id; b.acc = acc; b.full = full; b.s = s; b.e = e;
      b.valid = valid; b.total = kept_n[5:0]; b.last = last;
      pending_beats.push_back(b);
   endfunction

   function automatic void insert_entry(int pos, longint s, longint e, longint w,
                                        logic [15:0] id);
      for (int i = kept_n; i > pos; i--) begin
         kept_lo[i] = kept_lo[i-1]; kept_hi[i] = kept_hi[i-1];
         kept_w[i] = kept_w[i-1]; kept_id[i] = kept_id[i-1];
      end
      kept_lo[pos] = s; kept_hi[pos] = e; kept_w[pos] = w; kept_id[pos] = id;
      kept_n++;
   endfunction

   // close the open group and resolve it against the kept table
   function automatic void resolve_group(logic [15:0] id, logic [30:0] st31,
                                         logic [30:0] en31);
      longint      st = st31;
      longint      en = en31;
      longint      w, alt, left_hi;
      logic [15:0] gone[$];
      bit          acc = 0, full = 0, overlap, has_next;
      int          li, lo, hi, r;
      w = group_scored ? group_sum : clamp_weight((en - st + 1) * 256);
      group_sum = 0;
      group_scored = 0;
      if (st > reach) begin
         if (kept_n >= DEPTH) full = 1;
         else begin
            insert_entry(kept_n, st, en, w, id);
            acc = 1;
         end
      end else begin
         li = -1;
         for (int i = 0; i < kept_n; i++) if (kept_lo[i] <= st) li = i;
         left_hi = li >= 0 ? kept_hi[li] : -1;
         has_next = li + 1 < kept_n;
         overlap = left_hi >= st || (has_next && kept_lo[li+1] <= en);
         if (overlap) begin
            alt = 0;
            lo = li;
            hi = li + 1;
            while (lo >= 0 && kept_hi[lo] >= st) begin alt += kept_w[lo]; lo--; end
            lo++;
            while (hi < kept_n && kept_lo[hi] <= en) begin alt += kept_w[hi]; hi++; end
            hi--;
            if (w > alt) begin
               for (int i = lo; i <= hi; i++) gone.push_back(kept_id[i]);
               r = hi - lo + 1;
               for (int i = lo; i + r < kept_n; i++) begin
                  kept_lo[i] = kept_lo[i+r]; kept_hi[i] = kept_hi[i+r];
                  kept_w[i] = kept_w[i+r]; kept_id[i] = kept_id[i+r];
               end
               kept_n -= r;
               insert_entry(lo, st, en, w, id);
               acc = 1;
            end
         end else if (kept_n >= DEPTH) begin
            full = 1;
         end else begin
            insert_entry(li + 1, st, en, w, id);
            acc = 1;
         end
      end
      if (acc) begin
         if (en > reach) reach = en;
      end else begin
         gone.push_back(id);
      end
      foreach (gone[i]) push_beat(KIND_DISCARD, gone[i], 0, 0, '0, '0, 0, 0);
      push_beat(KIND_DECISION, id, acc, full, '0, '0, 0, 1);
   endfunction

   // work out the results of one accepted item
   function automatic void predict_item();
      case (req_operation)
         OP_FEATURE: begin
            if (!req_score_null) begin
               group_sum = clamp_weight(group_sum + longint'($signed(req_feature_score)));
               group_scored = 1;
            end
         end
         OP_READ: begin
            if (req_read_index < kept_n)
               push_beat(KIND_ENTRY, kept_id[req_read_index], 0, 0,
                         kept_lo[req_read_index][30:0], kept_hi[req_read_index][30:0], 1, 1);
            else
               push_beat(KIND_ENTRY, '0, 0, 0, '0, '0, 0, 1);
         end
         OP_CLOSE: resolve_group(req_group_id, req_group_start, req_group_end);
         default: ;
      endcase
   endfunction

   // send one item: gap, drive at the falling edge, wait for acceptance
   task automatic send_item(logic [1:0] op, logic [15:0] id, logic [31:0] score,
                            logic snull, logic [30:0] st, logic [30:0] en,
                            logic [4:0] idx);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_operation = op;
      req_group_id = id;
      req_feature_score = score;
      req_score_null = snull;
      req_group_start = st;
      req_group_end = en;
      req_read_index = idx;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predict_item();
   endtask

   task automatic add_score(logic [31:0] score, logic snull = 1'b0);
      send_item(OP_FEATURE, 16'($urandom), score, snull, 31'($urandom), 31'($urandom),
                5'($urandom));
   endtask

   task automatic close_group(logic [15:0] id, logic [30:0] st, logic [30:0] en);
      send_item(OP_CLOSE, id, $urandom, 1'($urandom), st, en, 5'($urandom));
   endtask

   task automatic read_entry(logic [4:0] idx);
      send_item(OP_READ, 16'($urandom), $urandom, 1'($urandom), 31'($urandom),
                31'($urandom), idx);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid) begin
         if (pending_beats.size() == 0) begin
            report_mismatch("unexpected beat, kind", 32'(rsp_kind), 32'd0);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
            if (rsp_out_group_id !== want.id)
               report_mismatch("group id", 32'(rsp_out_group_id), 32'(want.id));
            if (rsp_accepted !== want.acc)
               report_mismatch("accepted", 32'(rsp_accepted), 32'(want.acc));
            if (rsp_table_full !== want.full)
               report_mismatch("table full", 32'(rsp_table_full), 32'(want.full));
            if (rsp_entry_start !== want.s)
               report_mismatch("entry start", 32'(rsp_entry_start), 32'(want.s));
            if (rsp_entry_end !== want.e)
               report_mismatch("entry end", 32'(rsp_entry_end), 32'(want.e));
            if (rsp_entry_valid !== want.valid)
               report_mismatch("entry valid", 32'(rsp_entry_valid), 32'(want.valid));
            if (rsp_kept_total !== want.total)
               report_mismatch("kept total", 32'(rsp_kept_total), 32'(want.total));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   // fill the table by appends, then overflow it both at the end and in a gap
   task automatic test_table_full();
      read_entry(5'd0);
      for (int i = 0; i < 33; i++)
         close_group(16'(16'h100 + i), 31'(100 * i), 31'(100 * i + 10));
      close_group(16'hfff0, 31'd50, 31'd60);
      read_entry(5'd31);
   endtask

   // replacement of several entries and a lighter group dropped
   task automatic test_overlap();
      add_score(32'd100000);
      add_score(32'hdead, 1'b1);
      close_group(16'h0200, 31'd5, 31'd250);
      add_score(32'd1);
      close_group(16'h0201, 31'd400, 31'd400);
      close_group(16'h0202, 31'd1000, 31'd900);
      close_group(16'hffff, 31'd300, 31'd305);
      read_entry(5'd0);
      read_entry(5'd1);
   endtask

   // saturation of the score sum and of the span weight
   task automatic test_saturation();
      no_gaps = 1;
      for (int i = 0; i < 260; i++) add_score(32'h7fffffff);
      close_group(16'h0300, CMAX - 31'd20, CMAX);
      for (int i = 0; i < 4; i++) add_score(32'h80000000);
      add_score(32'h00000001);
      close_group(16'h0301, 31'd3000, 31'd3005);
      no_gaps = 0;
      close_group(16'h0302, 31'd0, CMAX);
      send_item(OP_UNUSED, 16'($urandom), $urandom, 1'($urandom), 31'($urandom),
                31'($urandom), 5'($urandom));
      read_entry(5'd31);
   endtask

   // random groups with scores mostly in a narrow window, reads and noise
   task automatic test_random();
      int          nfeat;
      logic [30:0] st, len;
      for (int k = 0; k < 15; k++) begin
         no_gaps = (k / 5) % 3 == 1;
         case ($urandom_range(0, 9))
            0, 1: read_entry(5'($urandom));
            2: send_item(OP_UNUSED, 16'($urandom), $urandom, 1'($urandom), 31'($urandom),
                         31'($urandom), 5'($urandom));
            default: begin
               nfeat = $urandom_range(0, 3);
               for (int f = 0; f < nfeat; f++) begin
                  if ($urandom_range(0, 9) == 0) add_score($urandom);
                  else add_score($urandom_range(0, 8000) - 1000, $urandom_range(0, 4) == 0);
               end
               if ($urandom_range(0, 19) == 0) begin
                  st = 31'($urandom);
                  len = 31'($urandom);
               end else begin
                  st = 31'($urandom_range(0, 4000));
                  len = 31'($urandom_range(0, 40));
               end
               if ($urandom_range(0, 15) == 0) close_group(16'($urandom), st, st - len);
               else close_group(16'($urandom), st, st + len);
            end
         endcase
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_table_full();
      test_overlap();
      test_saturation();
      test_random();
      @(negedge clock);
      start = 1'b0;
      wait (pending_beats.size() == 0);
      repeat (150) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // hard limit on the run
   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
